>>> design/pixs_pkg.sv
// shared types for the piecewise inverse polynomial cross section unit
// port payload structs, action codes and the request/response bundle of the float unit
// no dependencies
package pixs_pkg;

  localparam logic [1:0] ACT_QUERY    = 2'd0;
  localparam logic [1:0] ACT_BOUNDARY = 2'd1;
  localparam logic [1:0] ACT_COEF     = 2'd2;
  localparam logic [1:0] ACT_COUNT    = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  material;
    logic [6:0]  slot;
    logic [63:0] value;
    logic [63:0] energy;
  } in_t;

  typedef struct packed {
    logic [63:0] cross_section;
    logic [4:0]  interval_used;
  } out_t;

  typedef enum logic [1:0] {
    FOP_DIV,
    FOP_MUL,
    FOP_ADD
  } fop_t;

  typedef struct packed {
    logic        start;
    fop_t        op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } fpu_rsp_t;

endpackage

>>> design/pixs_fpu.sv
// multi-cycle double precision unit: reciprocal (1/a), multiply and add
// round to nearest even with subnormals; uses pixs_pkg request/response types
module pixs_fpu (
  input  logic               clk,
  input  logic               rst,
  input  pixs_pkg::fpu_req_t req,
  output pixs_pkg::fpu_rsp_t rsp
);

  localparam logic [63:0] QBIT   = 64'h0008_0000_0000_0000;
  localparam logic [63:0] DEFNAN = 64'hFFF8_0000_0000_0000;

  typedef struct packed {
    logic               s;
    logic signed [13:0] e;
    logic [52:0]        m;
    logic               zero;
    logic               inf;
    logic               nan;
  } fp_t;

  typedef enum logic [3:0] {
    F_IDLE, F_DSET, F_DIV, F_DFIN, F_MSET, F_MUL, F_MFIN, F_ASET, F_ADD, F_PACK
  } fstate_t;

  function automatic logic [5:0] lzc56(input logic [55:0] v);
    logic [5:0] n;
    logic       hit;
    n   = 6'd0;
    hit = 1'b0;
    for (int i = 55; i >= 0; i--) begin
      if (!hit) begin
        if (v[i]) hit = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  function automatic fp_t unpack(input logic [63:0] x);
    fp_t         r;
    logic [52:0] m0;
    logic [5:0]  lz;
    r.s    = x[63];
    r.nan  = (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
    r.inf  = (x[62:52] == 11'h7FF) && (x[51:0] == 52'd0);
    r.zero = (x[62:0] == 63'd0);
    m0     = {1'b0, x[51:0]};
    lz     = lzc56({m0, 3'b000});
    if (x[62:52] != 11'd0) begin
      r.e = $signed({3'b000, x[62:52]}) - 14'sd1023;
      r.m = {1'b1, x[51:0]};
    end else begin
      // subnormal: bring the leading one up to the hidden position
      r.e = -14'sd1022 - $signed({8'd0, lz});
      r.m = m0 << lz;
    end
    return r;
  endfunction

  function automatic logic [63:0] round_pack(input logic s, input logic signed [13:0] e,
                                             input logic [55:0] sig, input logic st);
    logic signed [13:0] biased;
    logic signed [13:0] sh;
    logic [55:0]        t;
    logic [55:0]        lostmask;
    logic [52:0]        m;
    logic               g;
    logic               rest;
    logic               inc;
    logic [10:0]        be1;
    logic [62:0]        w;
    biased   = e + 14'sd1023;
    sh       = 14'sd1 - biased;
    t        = 56'd0;
    lostmask = 56'd0;
    if (biased >= 14'sd1) begin
      m    = sig[55:3];
      g    = sig[2];
      rest = (|sig[1:0]) | st;
      be1  = 11'(biased - 14'sd1);
    end else begin
      // result falls into the subnormal range
      if (sh >= 14'sd58) begin
        rest = (|sig) | st;
      end else begin
        t        = sig >> sh[5:0];
        lostmask = (56'd1 << sh[5:0]) - 56'd1;
        rest     = (|(sig & lostmask)) | (|t[1:0]) | st;
      end
      m   = t[55:3];
      g   = t[2];
      be1 = 11'd0;
    end
    inc = g & (rest | m[0]);
    // hidden bit carries into the exponent field, rounding carry too
    w = {be1, 52'd0} + 63'(m) + 63'(inc);
    if (biased >= 14'sd2047) return {s, 11'h7FF, 52'd0};
    return {s, w};
  endfunction

  fstate_t            state;
  fp_t                ua;
  fp_t                ub;
  logic [63:0]        araw;
  logic [63:0]        braw;
  logic [53:0]        rem;
  logic [57:0]        q;
  logic [4:0]         step;
  logic [105:0]       prod;
  logic [55:0]        xs;
  logic [55:0]        yal;
  logic               sub;
  logic               pk_special;
  logic [63:0]        pk_bits;
  logic               pk_s;
  logic signed [13:0] pk_e;
  logic [55:0]        pk_sig;
  logic               pk_st;

  logic [53:0]        div_rem_next;
  logic [57:0]        div_q_next;
  logic [26:0]        pa;
  logic [26:0]        pb;
  logic [53:0]        pp;
  logic [105:0]       mul_next;
  logic               a_big;
  fp_t                xo;
  fp_t                yo;
  logic signed [13:0] d;
  logic [55:0]        y56;
  logic [55:0]        ys;
  logic               yst;
  logic [56:0]        sum57;
  logic [55:0]        diff;
  logic [5:0]         lz;

  // two restoring steps per cycle
  always_comb begin
    div_rem_next = rem;
    div_q_next   = q;
    for (int j = 0; j < 2; j++) begin
      if (div_rem_next >= {1'b0, ua.m}) begin
        div_rem_next = div_rem_next - {1'b0, ua.m};
        div_q_next   = {div_q_next[56:0], 1'b1};
      end else begin
        div_q_next   = {div_q_next[56:0], 1'b0};
      end
      div_rem_next = {div_rem_next[52:0], 1'b0};
    end
  end

  // one 27x27 partial product per cycle
  always_comb begin
    pa = ua.m[26:0];
    pb = ub.m[26:0];
    case (step[1:0])
      2'd1:    pb = {1'b0, ub.m[52:27]};
      2'd2:    pa = {1'b0, ua.m[52:27]};
      2'd3: begin
        pa = {1'b0, ua.m[52:27]};
        pb = {1'b0, ub.m[52:27]};
      end
      default: ;
    endcase
    pp = pa * pb;
    case (step[1:0])
      2'd0:    mul_next = prod + 106'(pp);
      2'd3:    mul_next = prod + (106'(pp) << 54);
      default: mul_next = prod + (106'(pp) << 27);
    endcase
  end

  always_comb begin
    a_big = (ua.e > ub.e) || ((ua.e == ub.e) && (ua.m >= ub.m));
    xo    = a_big ? ua : ub;
    yo    = a_big ? ub : ua;
    d     = xo.e - yo.e;
    y56   = {yo.m, 3'b000};
    if (d >= 14'sd56) begin
      ys  = 56'd0;
      yst = 1'b1;
    end else begin
      ys  = y56 >> d[5:0];
      yst = |(y56 & ((56'd1 << d[5:0]) - 56'd1));
    end
    sum57 = {1'b0, xs} + {1'b0, yal};
    diff  = xs - yal;
    lz    = lzc56(diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        F_IDLE: begin
          if (req.start) begin
            ua   <= unpack(req.a);
            ub   <= unpack(req.b);
            araw <= req.a;
            braw <= req.b;
            case (req.op)
              pixs_pkg::FOP_DIV: state <= F_DSET;
              pixs_pkg::FOP_MUL: state <= F_MSET;
              default:           state <= F_ASET;
            endcase
          end
        end
        F_DSET: begin
          pk_special <= 1'b1;
          pk_st      <= 1'b0;
          step       <= 5'd0;
          rem        <= 54'h10_0000_0000_0000;
          q          <= 58'd0;
          state      <= F_PACK;
          if (ua.nan) pk_bits <= araw | QBIT;
          else if (ua.zero) pk_bits <= {ua.s, 11'h7FF, 52'd0};
          else if (ua.inf) pk_bits <= {ua.s, 63'd0};
          else begin
            pk_special <= 1'b0;
            state      <= F_DIV;
          end
        end
        F_DIV: begin
          rem  <= div_rem_next;
          q    <= div_q_next;
          step <= step + 5'd1;
          if (step == 5'd28) state <= F_DFIN;
        end
        F_DFIN: begin
          pk_s <= ua.s;
          if (q[57]) begin
            pk_sig <= q[57:2];
            pk_st  <= (|q[1:0]) | (rem != 54'd0);
            pk_e   <= -ua.e;
          end else begin
            pk_sig <= q[56:1];
            pk_st  <= q[0] | (rem != 54'd0);
            pk_e   <= -ua.e - 14'sd1;
          end
          state <= F_PACK;
        end
        F_MSET: begin
          prod       <= 106'd0;
          step       <= 5'd0;
          pk_special <= 1'b1;
          pk_s       <= ua.s ^ ub.s;
          state      <= F_PACK;
          if (ua.nan) pk_bits <= araw | QBIT;
          else if (ub.nan) pk_bits <= braw | QBIT;
          else if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) pk_bits <= DEFNAN;
          else if (ua.inf || ub.inf) pk_bits <= {ua.s ^ ub.s, 11'h7FF, 52'd0};
          else if (ua.zero || ub.zero) pk_bits <= {ua.s ^ ub.s, 63'd0};
          else begin
            pk_special <= 1'b0;
            state      <= F_MUL;
          end
        end
        F_MUL: begin
          prod <= mul_next;
          step <= step + 5'd1;
          if (step == 5'd3) state <= F_MFIN;
        end
        F_MFIN: begin
          if (prod[105]) begin
            pk_sig <= prod[105:50];
            pk_st  <= |prod[49:0];
            pk_e   <= ua.e + ub.e + 14'sd1;
          end else begin
            pk_sig <= prod[104:49];
            pk_st  <= |prod[48:0];
            pk_e   <= ua.e + ub.e;
          end
          state <= F_PACK;
        end
        F_ASET: begin
          pk_special <= 1'b1;
          pk_st      <= 1'b0;
          state      <= F_PACK;
          if (ua.nan) pk_bits <= araw | QBIT;
          else if (ub.nan) pk_bits <= braw | QBIT;
          else if (ua.inf && ub.inf && (ua.s != ub.s)) pk_bits <= DEFNAN;
          else if (ua.inf) pk_bits <= araw;
          else if (ub.inf) pk_bits <= braw;
          else if (ua.zero && ub.zero) pk_bits <= {ua.s & ub.s, 63'd0};
          else if (ua.zero) pk_bits <= braw;
          else if (ub.zero) pk_bits <= araw;
          else begin
            pk_special <= 1'b0;
            xs         <= {xo.m, 3'b000};
            yal        <= ys | {55'd0, yst};
            sub        <= xo.s ^ yo.s;
            pk_s       <= xo.s;
            pk_e       <= xo.e;
            state      <= F_ADD;
          end
        end
        F_ADD: begin
          state <= F_PACK;
          if (!sub) begin
            if (sum57[56]) begin
              pk_sig <= {sum57[56:2], sum57[1] | sum57[0]};
              pk_e   <= pk_e + 14'sd1;
            end else begin
              pk_sig <= sum57[55:0];
            end
          end else if (diff == 56'd0) begin
            // exact cancellation gives +0
            pk_special <= 1'b1;
            pk_bits    <= 64'd0;
          end else begin
            pk_sig <= diff << lz;
            pk_e   <= pk_e - $signed({8'd0, lz});
          end
        end
        F_PACK: begin
          rsp.result <= pk_special ? pk_bits : round_pack(pk_s, pk_e, pk_sig, pk_st);
          rsp.done   <= 1'b1;
          state      <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> design/piecewise_inverse_poly_xsec_unit.sv
// top level of the piecewise inverse polynomial cross section unit
// boundary and coefficient memories, interval search and Horner sequencing
// depends on pixs_pkg and pixs_fpu
//
// Usage: present an item on item and raise start; it transfers on a rising edge
// with start high and busy low. Actions 1..3 load a boundary, a coefficient or an
// interval count; they produce no result and leave busy low.
// A query raises busy and ends with done high for one cycle, result valid in that
// cycle; the receiver cannot stall, so the result must be taken then.
// A query first starts the reciprocal in the shared float unit while the boundary
// search reads one memory entry per cycle (up to INTERVALS+1 reads) and then waits
// for the reciprocal if it is still running; then seven Horner steps run one at a
// time through the same unit, each preceded by a coefficient fetch. Zero, infinite or
// not-a-number operands end a step early.
// Busy drops with done, so the next item can transfer at the edge ending done.
// A query on a material outside the table does not raise busy and answers zero in the next cycle.
// Reset clears the interval counts and the control state; the boundary and
// coefficient memories hold whatever was written and are not cleared.
module piecewise_inverse_poly_xsec_unit #(
  parameter int MATERIALS = 16,
  parameter int INTERVALS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pixs_pkg::in_t  item,
  output logic           done,
  output pixs_pkg::out_t result
);

  localparam int TERMS  = 4;
  localparam int MW     = (MATERIALS > 1) ? $clog2(MATERIALS) : 1;
  localparam int IW     = (INTERVALS > 1) ? $clog2(INTERVALS) : 1;
  localparam int BDEPTH = MATERIALS * INTERVALS;
  localparam int CDEPTH = MATERIALS * INTERVALS * TERMS;
  localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int CAW    = $clog2(CDEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_CHK0, S_SCAN, S_WDIV, S_FETCH, S_OP, S_WOP
  } state_t;

  function automatic logic [BAW-1:0] baddr(input logic [MW-1:0] m, input logic [IW-1:0] i);
    return BAW'(m) * BAW'(INTERVALS) + BAW'(i);
  endfunction

  // a >= b on doubles, false when either is not a number
  function automatic logic fge(input logic [63:0] a, input logic [63:0] b);
    logic an;
    logic bn;
    an = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    bn = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    if (an || bn) return 1'b0;
    if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) return 1'b1;
    if (a[63] != b[63]) return b[63];
    if (!a[63]) return a[62:0] >= b[62:0];
    return a[62:0] <= b[62:0];
  endfunction

  logic [63:0]        bnd_mem [BDEPTH];
  logic [63:0]        coef_mem [CDEPTH];
  logic [5:0]         counts [MATERIALS];

  state_t             state;
  logic [63:0]        energy_q;
  logic [MW-1:0]      mat_q;
  logic [5:0]         cnt_q;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      sel;
  logic [63:0]        u;
  logic               u_ok;
  logic [63:0]        acc;
  logic [2:0]         k;
  logic [63:0]        bnd_q;
  logic [63:0]        coef_q;
  pixs_pkg::fpu_req_t fpu_req;
  pixs_pkg::fpu_rsp_t fpu_rsp;

  logic               accept;
  logic [8:0]         mat_ext;
  logic [MW-1:0]      mat_in;
  logic               mat_ok;
  logic [BAW-1:0]     bnd_raddr;
  logic [CAW-1:0]     coef_raddr;
  logic [1:0]         term;
  logic [5:0]         cnt_w;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign mat_ext = {5'd0, item.material};
  assign mat_in  = mat_ext[MW-1:0];
  assign mat_ok  = mat_ext < 9'(MATERIALS);
  assign term    = 2'd3 - 2'((k + 3'd1) >> 1);
  assign cnt_w   = (7'(item.value[5:0]) > 7'(INTERVALS)) ? 6'(INTERVALS) : item.value[5:0];

  always_comb begin
    unique case (state)
      S_IDLE:  bnd_raddr = baddr(mat_in, IW'(0));
      S_CHK0:  bnd_raddr = baddr(mat_q, IW'(cnt_q - 6'd1));
      default: bnd_raddr = baddr(mat_q, idx - IW'(1));
    endcase
    coef_raddr = CAW'(mat_q) * CAW'(INTERVALS * TERMS) + CAW'(sel) * CAW'(TERMS) + CAW'(term);
  end

  always_ff @(posedge clk) begin
    if (accept && (item.action == pixs_pkg::ACT_BOUNDARY) && mat_ok &&
        (item.slot < INTERVALS)) begin
      bnd_mem[baddr(mat_in, item.slot[IW-1:0])] <= item.value;
    end
    bnd_q <= bnd_mem[bnd_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && (item.action == pixs_pkg::ACT_COEF) && mat_ok &&
        (item.slot < INTERVALS * TERMS)) begin
      coef_mem[CAW'(mat_in) * CAW'(INTERVALS * TERMS) + CAW'(item.slot)] <= item.value;
    end
    coef_q <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MATERIALS; i++) counts[i] <= 6'd0;
    end else if (accept && (item.action == pixs_pkg::ACT_COUNT) && mat_ok) begin
      counts[mat_in] <= cnt_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      u_ok          <= 1'b0;
      fpu_req.start <= 1'b0;
    end else begin
      done          <= 1'b0;
      fpu_req.start <= 1'b0;
      // the reciprocal finishes while the search may still run
      if (fpu_rsp.done && !u_ok) begin
        u    <= fpu_rsp.result;
        u_ok <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (item.action == pixs_pkg::ACT_QUERY)) begin
            if (!mat_ok) begin
              result <= '0;
              done   <= 1'b1;
            end else begin
              energy_q      <= item.energy;
              mat_q         <= mat_in;
              cnt_q         <= counts[mat_in];
              u_ok          <= 1'b0;
              fpu_req.start <= 1'b1;
              fpu_req.op    <= pixs_pkg::FOP_DIV;
              fpu_req.a     <= item.energy;
              fpu_req.b     <= item.energy;
              state         <= S_CHK0;
            end
          end
        end
        S_CHK0: begin
          if (!fge(energy_q, bnd_q) || (cnt_q == 6'd0)) begin
            sel   <= IW'(0);
            state <= S_WDIV;
          end else begin
            idx   <= IW'(cnt_q - 6'd1);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (fge(energy_q, bnd_q) || (idx == IW'(0))) begin
            sel   <= idx;
            state <= S_WDIV;
          end else begin
            idx <= idx - IW'(1);
          end
        end
        S_WDIV: begin
          if (u_ok) begin
            k     <= 3'd0;
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_OP;
        S_OP: begin
          fpu_req.start <= 1'b1;
          if (k[0]) begin
            fpu_req.op <= pixs_pkg::FOP_ADD;
            fpu_req.a  <= coef_q;
            fpu_req.b  <= acc;
          end else begin
            fpu_req.op <= pixs_pkg::FOP_MUL;
            fpu_req.a  <= u;
            fpu_req.b  <= (k == 3'd0) ? coef_q : acc;
          end
          state <= S_WOP;
        end
        S_WOP: begin
          if (fpu_rsp.done && u_ok) begin
            if (k == 3'd6) begin
              result.cross_section <= fpu_rsp.result;
              result.interval_used <= 5'(sel);
              done                 <= 1'b1;
              state                <= S_IDLE;
            end else begin
              acc   <= fpu_rsp.result;
              k     <= k + 3'd1;
              state <= S_FETCH;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  pixs_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (fpu_req),
    .rsp (fpu_rsp)
  );

endmodule

>>> tb/sv/tb_piecewise_inverse_poly_xsec_unit.sv
// testbench for piecewise_inverse_poly_xsec_unit: table loads and cross section queries
// checked against an in-bench double precision predictor of the table lookup and Horner sum
// depends on pixs_pkg and the unit under test
module tb_piecewise_inverse_poly_xsec_unit;

  localparam int MATS = 16;
  localparam int INTS = 32;
  localparam int TIMEOUT_CYCLES = 2000000;

  localparam logic [63:0] DBL_INF = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] DBL_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] DBL_TWO = 64'h4000_0000_0000_0000;
  localparam logic [63:0] DBL_NEG_TWO = 64'hC000_0000_0000_0000;
  localparam logic [63:0] DBL_MAX = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DBL_TINY = 64'h0010_0000_0000_0000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  pixs_pkg::in_t item;
  logic done;
  pixs_pkg::out_t result;

  piecewise_inverse_poly_xsec_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result)
  );

  // predictor state
  logic [63:0] bound_tab[MATS][INTS];
  logic [63:0] coef_tab[MATS][INTS*4];
  logic [5:0] count_tab[MATS];

  pixs_pkg::out_t xsec_expected[$];
  int err_count = 0;
  int cycle_count = 0;

  typedef struct {
    pixs_pkg::in_t it;
    bit typed;
    pixs_pkg::out_t want;
  } row_t;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic bit predict_xsec(pixs_pkg::in_t it, output pixs_pkg::out_t r);
    int m;
    int cnt;
    int sel;
    real e;
    real u;
    real acc;
    r = '0;
    m = it.material;
    case (it.action)
      pixs_pkg::ACT_BOUNDARY: begin
        if (it.slot < INTS) bound_tab[m][it.slot] = it.value;
        return 1'b0;
      end
      pixs_pkg::ACT_COEF: begin
        coef_tab[m][it.slot] = it.value;
        return 1'b0;
      end
      pixs_pkg::ACT_COUNT: begin
        count_tab[m] = (it.value[5:0] > INTS) ? 6'(INTS) : it.value[5:0];
        return 1'b0;
      end
      default: begin
        e = $bitstoreal(it.energy);
        cnt = count_tab[m];
        sel = 0;
        if (e >= $bitstoreal(bound_tab[m][0])) begin
          for (int i = cnt; i > 0; i--) begin
            if (e >= $bitstoreal(bound_tab[m][i-1])) begin
              sel = i - 1;
              break;
            end
          end
        end
        u = 1.0 / e;
        acc = u * $bitstoreal(coef_tab[m][sel*4+3]);
        acc = $bitstoreal(coef_tab[m][sel*4+2]) + acc;
        acc = u * acc;
        acc = $bitstoreal(coef_tab[m][sel*4+1]) + acc;
        acc = u * acc;
        acc = $bitstoreal(coef_tab[m][sel*4]) + acc;
        acc = u * acc;
        r.cross_section = $realtobits(acc);
        r.interval_used = 5'(sel);
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    pixs_pkg::out_t want;
    if (!rst && done) begin
      if (xsec_expected.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result xs=%h iv=%0d", result.cross_section,
                   result.interval_used);
      end else begin
        want = xsec_expected.pop_front();
        if (result.cross_section !== want.cross_section ||
            result.interval_used !== want.interval_used) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected xs=%h iv=%0d, got xs=%h iv=%0d",
                     want.cross_section, want.interval_used,
                     result.cross_section, result.interval_used);
        end
      end
    end
  end

  function automatic logic [63:0] rand_dbl(int exp_lo, int exp_hi, bit neg);
    return {neg, 11'($urandom_range(exp_hi, exp_lo)), 20'($urandom), $urandom};
  endfunction

  // materials whose tables are fully loaded and may be queried
  function automatic int mat_of(int k);
    return (k == 4) ? MATS - 1 : k;
  endfunction

  // one transfer; the gap before the next item is drawn afterwards
  task automatic send_item(pixs_pkg::in_t it, bit typed, pixs_pkg::out_t want, int gap);
    pixs_pkg::out_t pred;
    @(negedge clk);
    item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (predict_xsec(it, pred)) xsec_expected.push_back(typed ? want : pred);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (xsec_expected.size() != 0) @(posedge clk);
  endtask

  function automatic pixs_pkg::in_t mk(logic [1:0] a, int m, int s, logic [63:0] v,
                                       logic [63:0] e);
    pixs_pkg::in_t it;
    it.action = a;
    it.material = 4'(m);
    it.slot = 7'(s);
    it.value = v;
    it.energy = e;
    return it;
  endfunction

  function automatic pixs_pkg::in_t random_item();
    pixs_pkg::in_t it;
    int m;
    int pick;
    it.action = 2'($urandom);
    it.material = 4'($urandom);
    it.slot = 7'($urandom);
    it.value = {$urandom, $urandom};
    it.energy = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 55) begin
      it.action = pixs_pkg::ACT_QUERY;
      it.material = 4'(mat_of($urandom_range(4)));
      m = it.material;
      pick = $urandom_range(99);
      if (pick < 8) it.energy = {$urandom, $urandom};
      else if (pick < 14) begin
        case ($urandom_range(4))
          0: it.energy = 64'd0;
          1: it.energy = 64'h8000_0000_0000_0000;
          2: it.energy = DBL_INF;
          3: it.energy = DBL_NAN;
          default: it.energy = rand_dbl(990, 1040, 1'b1);
        endcase
      end else if (pick < 40) it.energy = bound_tab[m][$urandom_range(INTS-1)];
      else it.energy = rand_dbl(995, 1035, 1'b0);
    end else if (pick < 70) begin
      it.action = pixs_pkg::ACT_BOUNDARY;
      if ($urandom_range(9) == 0) it.slot = 7'($urandom_range(127));
      else begin
        it.slot = 7'($urandom_range(INTS-1));
        it.value = (it.slot[0] && $urandom_range(7) == 0) ? {$urandom, $urandom} :
                   {1'b0, 11'(1000 + it.slot), 20'($urandom), $urandom};
      end
    end else if (pick < 90) begin
      it.action = pixs_pkg::ACT_COEF;
      if ($urandom_range(19) != 0) it.value = rand_dbl(1000, 1040, $urandom_range(1));
    end else begin
      it.action = pixs_pkg::ACT_COUNT;
      it.value[5:0] = ($urandom_range(5) == 0) ? 6'($urandom_range(63)) :
                      6'($urandom_range(INTS));
    end
    return it;
  endfunction

  initial begin
    row_t rows[$];
    pixs_pkg::out_t none;
    int burst;
    none = '0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int m = 0; m < MATS; m++) count_tab[m] = '0;

    // fill every entry of the queried materials so that no query reads an unwritten one
    for (int k = 0; k < 5; k++) begin
      for (int s = 0; s < INTS; s++)
        send_item(mk(pixs_pkg::ACT_BOUNDARY, mat_of(k), s, {1'b0, 11'(1000 + s), 52'd0},
                     64'd0), 1'b0, none, $urandom_range(1));
      for (int s = 0; s < INTS*4; s++)
        send_item(mk(pixs_pkg::ACT_COEF, mat_of(k), s, rand_dbl(1000, 1040, 1'b0), 64'd0),
                  1'b0, none, $urandom_range(1));
    end

    rows.push_back('{mk(pixs_pkg::ACT_QUERY, 0, 0, 0, DBL_TWO), 0, none});
    rows.push_back('{mk(pixs_pkg::ACT_COUNT, 0, 0, 64'd32, 0), 0, none});
    rows.push_back('{mk(pixs_pkg::ACT_QUERY, 0, 0, 0, DBL_INF), 1, '{64'd0, 5'd31}});
    rows.push_back('{mk(pixs_pkg::ACT_QUERY, 0, 0, 0, 64'd0), 0, none});
    rows.push_back('{mk(pixs_pkg::ACT_QUERY, 0, 0, 0, DBL_TINY), 0, none});
    rows.push_back('{mk(pixs_pkg::ACT_QUERY, 0, 0, 0, DBL_NAN), 0, none});
    rows.push_back('{mk(pixs_pkg::ACT_QUERY, 0, 0, 0, {1'b0, 11'd1005, 52'd0}), 0, none});
    rows.push_back('{mk(pixs_pkg::ACT_QUERY, 0, 0, 0, DBL_NEG_TWO), 0, none});
    rows.push_back('{mk(pixs_pkg::ACT_QUERY, 0, 0, 0, 64'd1), 0, none});
    rows.push_back('{mk(pixs_pkg::ACT_COUNT, 1, 0, ALL_ONES, 0), 0, none});
    rows.push_back('{mk(pixs_pkg::ACT_QUERY, 1, 0, 0, DBL_MAX), 0, none});
    rows.push_back('{mk(pixs_pkg::ACT_QUERY, 15, 0, 0, DBL_MAX), 0, none});
    rows.push_back('{mk(pixs_pkg::ACT_COUNT, 15, 0, 64'd1, 0), 0, none});
    rows.push_back('{mk(pixs_pkg::ACT_QUERY, 15, 127, ALL_ONES, DBL_MAX), 0, none});
    rows.push_back('{mk(pixs_pkg::ACT_BOUNDARY, 3, 127, ALL_ONES, ALL_ONES), 0, none});
    rows.push_back('{mk(pixs_pkg::ACT_COEF, 15, 127, ALL_ONES, 0), 0, none});
    rows.push_back('{mk(pixs_pkg::ACT_COUNT, 2, 0, 64'd33, 0), 0, none});
    rows.push_back('{mk(pixs_pkg::ACT_QUERY, 2, 0, 0, DBL_INF), 1, '{64'd0, 5'd31}});
    rows.push_back('{mk(pixs_pkg::ACT_QUERY, 3, 0, 0, {1'b0, 11'd1031, 52'd0}), 0, none});
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want, $urandom_range(3));

    // hold off the sender until every queued answer has been seen
    drain_results();

    burst = 0;
    for (int n = 0; n < 780; n++) begin
      if (burst == 0 && $urandom_range(19) == 0) burst = $urandom_range(60, 20);
      if (burst > 0) burst--;
      send_item(random_item(), 1'b0, none, (burst > 0) ? 0 : $urandom_range(3));
      if (n == 390) drain_results();
    end
    drain_results();
    repeat (200) @(posedge clk);

    if (err_count == 0 && xsec_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
design/pixs_pkg.sv
design/pixs_fpu.sv
design/piecewise_inverse_poly_xsec_unit.sv
tb/sv/tb_piecewise_inverse_poly_xsec_unit.sv
